/* src/mmtf_pkg.sv */
package mmtf_pkg;

  localparam int DEPTH  = 16;
  localparam int VAL_W  = 32;
  localparam int HELD_W = 5;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  // contents of one cell: its entry plus max/min over it and every younger entry
  typedef struct packed {
    logic                    valid;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] smax;
    logic signed [VAL_W-1:0] smin;
  } cell_st_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

/* src/min_max_tracking_fifo_unit.sv */
// queue of signed 32-bit values, up to 16 entries, with live largest and smallest
//
// command channel: a beat is taken at a clock edge with start high and busy low;
// in_func selects push (in_value goes to the tail) or pop (oldest entry leaves)
// busy stays low, so a command can be issued in every cycle
//
// result channel: one beat per command, shown on the out_ ports for exactly one
// cycle with out_strobe high, the cycle after the command is taken; the receiver
// cannot hold results off, so results are never stalled
// throughput is one command per cycle, set by the row of
// cells, which shifts toward the head on a pop and updates every held cell on a push
//
// each cell keeps max/min over itself and all younger entries, so the head cell
// always carries the extremes of the whole queue and no rescan is needed
// refused operations (pop from empty, push into full) report out_ok low and
// leave the queue untouched; the popped field reads most negative when unused
//
// reset (rst_n low, synchronous) empties the queue at once; no clearing pass
module min_max_tracking_fifo_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_func,
  input  logic signed [mmtf_pkg::VAL_W-1:0]    in_value,
  output logic                                 out_strobe,
  output logic                                 out_ok,
  output logic signed [mmtf_pkg::VAL_W-1:0]    out_popped,
  output logic        [mmtf_pkg::HELD_W-1:0]   out_held,
  output logic signed [mmtf_pkg::VAL_W-1:0]    out_largest,
  output logic signed [mmtf_pkg::VAL_W-1:0]    out_smallest
);
  import mmtf_pkg::*;

  cell_st_t  cell_st [DEPTH];
  cell_st_t  next_st [DEPTH];
  logic      prev_valid [DEPTH];
  cell_ctl_t ctl;

  logic             accept;
  logic             empty;
  logic             full;
  logic [CNT_W-1:0] count_r, count_nxt;

  // registered result beat
  logic                    strobe_r;
  logic                    ok_r;
  logic signed [VAL_W-1:0] popped_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // cells fill contiguously from the head
  assign empty = !cell_st[0].valid;
  assign full  = cell_st[DEPTH-1].valid;

  assign ctl.push = accept && (func_t'(in_func) == FUNC_PUSH) && !full;
  assign ctl.pop  = accept && (func_t'(in_func) == FUNC_POP) && !empty;

  // chain wiring: each cell sees the one behind it and the one ahead of it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) begin
        next_st[i] = '0;
      end else begin
        next_st[i] = cell_st[i+1];
      end
      if (i == 0) begin
        prev_valid[i] = 1'b1;
      end else begin
        prev_valid[i] = cell_st[i-1].valid;
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    mmtf_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .push_value (in_value),
      .prev_valid (prev_valid[g]),
      .next_st    (next_st[g]),
      .st         (cell_st[g])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  // result payload; the head cell's value is the one leaving on a pop
  always_ff @(posedge clk) begin
    ok_r     <= ctl.push || ctl.pop;
    popped_r <= ctl.pop ? cell_st[0].value : VAL_MIN;
  end

  assign out_strobe   = strobe_r;
  assign out_ok       = ok_r;
  assign out_popped   = popped_r;
  // cell registers already hold the post-command state in the result cycle
  assign out_held     = HELD_W'(count_r);
  assign out_largest  = cell_st[0].valid ? cell_st[0].smax : VAL_MIN;
  assign out_smallest = cell_st[0].valid ? cell_st[0].smin : VAL_MAX;

endmodule

/* src/mmtf_cell.sv */
module mmtf_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mmtf_pkg::cell_ctl_t                  ctl,
  input  logic signed [mmtf_pkg::VAL_W-1:0]    push_value,
  input  logic                                 prev_valid,
  input  mmtf_pkg::cell_st_t                   next_st,
  output mmtf_pkg::cell_st_t                   st
);
  import mmtf_pkg::*;

  logic                    valid_r, valid_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic signed [VAL_W-1:0] smax_r, smax_nxt;
  logic signed [VAL_W-1:0] smin_r, smin_nxt;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    smax_nxt  = smax_r;
    smin_nxt  = smin_r;
    if (ctl.pop) begin
      // shift toward the head
      valid_nxt = next_st.valid;
      value_nxt = next_st.value;
      smax_nxt  = next_st.smax;
      smin_nxt  = next_st.smin;
    end else if (ctl.push) begin
      if (valid_r) begin
        if (push_value > smax_r) smax_nxt = push_value;
        if (push_value < smin_r) smin_nxt = push_value;
      end else if (prev_valid) begin
        // first free cell is the tail
        valid_nxt = 1'b1;
        value_nxt = push_value;
        smax_nxt  = push_value;
        smin_nxt  = push_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    smax_r  <= smax_nxt;
    smin_r  <= smin_nxt;
  end

  assign st.valid = valid_r;
  assign st.value = value_r;
  assign st.smax  = smax_r;
  assign st.smin  = smin_r;

endmodule

/* verif/tb_min_max_tracking_fifo_unit.sv */
module tb_min_max_tracking_fifo_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import mmtf_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_CMDS  = 750;
  // idling stops for the final stretch of random commands
  localparam int QUIET_TAIL   = 100;
  localparam int DRAIN_CYCLES = 8;
  // the limit leaves a wide margin over the worst run
  localparam int CYCLE_LIMIT  = 100000;

  typedef logic signed [VAL_W-1:0] val_t;

  // one command beat waiting to go out
  typedef struct {
    func_t func;
    val_t  value;
    bit    gap_ok;       // sender may idle after this beat
    bit    drain_first;  // hold until every outstanding result is back
  } fifo_cmd_t;

  // what the result beat of one command should carry
  typedef struct {
    logic              ok;
    val_t              popped;
    logic [HELD_W-1:0] held;
    val_t              largest;
    val_t              smallest;
  } fifo_report_t;

  logic              clk          = 1'b0;
  logic              rst_n        = 1'b0;
  logic              start        = 1'b0;
  logic              in_func      = FUNC_PUSH;
  val_t              in_value     = '0;
  logic              busy;
  logic              out_strobe;
  logic              out_ok;
  val_t              out_popped;
  logic [HELD_W-1:0] out_held;
  val_t              out_largest;
  val_t              out_smallest;

  fifo_cmd_t    cmd_q[$];
  fifo_report_t pending_reports[$];
  int           fail_cnt  = 0;
  int           cycle_cnt = 0;
  int           idle_left = 0;

  // shadow of the queue contents as a ring, with running extremes
  val_t shadow_ring[DEPTH];
  int   shadow_head  = 0;
  int   shadow_count = 0;
  val_t shadow_max   = VAL_MIN;
  val_t shadow_min   = VAL_MAX;

  min_max_tracking_fifo_unit u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_strobe   (out_strobe),
    .out_ok       (out_ok),
    .out_popped   (out_popped),
    .out_held     (out_held),
    .out_largest  (out_largest),
    .out_smallest (out_smallest)
  );

  always #1 clk = ~clk;

  // apply one command to the shadow queue and return the report it should give
  function automatic fifo_report_t apply_fifo_cmd(func_t f, val_t v);
    fifo_report_t r;
    int idx;
    r.ok     = 1'b0;
    r.popped = VAL_MIN;
    if (f == FUNC_PUSH) begin
      // push into full is refused and leaves everything alone
      if (shadow_count < DEPTH) begin
        shadow_ring[(shadow_head + shadow_count) % DEPTH] = v;
        shadow_count++;
        if (v > shadow_max) shadow_max = v;
        if (v < shadow_min) shadow_min = v;
        r.ok = 1'b1;
      end
    end else if (shadow_count > 0) begin
      r.popped    = shadow_ring[shadow_head];
      shadow_head = (shadow_head + 1) % DEPTH;
      shadow_count--;
      // extremes recomputed over what is left; empty falls back to the sentinels
      shadow_max = VAL_MIN;
      shadow_min = VAL_MAX;
      for (idx = 0; idx < shadow_count; idx++) begin
        if (shadow_ring[(shadow_head + idx) % DEPTH] > shadow_max)
          shadow_max = shadow_ring[(shadow_head + idx) % DEPTH];
        if (shadow_ring[(shadow_head + idx) % DEPTH] < shadow_min)
          shadow_min = shadow_ring[(shadow_head + idx) % DEPTH];
      end
      r.ok = 1'b1;
    end
    r.held     = HELD_W'(shadow_count);
    r.largest  = shadow_max;
    r.smallest = shadow_min;
    return r;
  endfunction

  // values cluster at the extremes and near zero so ties happen often
  function automatic val_t pick_value();
    case ($urandom_range(0, 5))
      0:       return VAL_MIN + $urandom_range(0, 3);
      1:       return VAL_MAX - $urandom_range(0, 3);
      2:       return VAL_W'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(func_t f, val_t v, bit gap_ok, bit drain_first);
    fifo_cmd_t c;
    c.func        = f;
    c.value       = v;
    c.gap_ok      = gap_ok;
    c.drain_first = drain_first;
    cmd_q.push_back(c);
  endtask

  // command driver: a beat goes when start is high and busy is low
  always @(posedge clk) begin
    fifo_cmd_t nxt;
    if (rst_n) begin
      if (start && !busy)
        pending_reports.push_back(apply_fifo_cmd(func_t'(in_func), in_value));
      // free to change the command lines unless a beat is still being held off
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (cmd_q.size() != 0 &&
                     !(cmd_q[0].drain_first && pending_reports.size() != 0)) begin
          nxt = cmd_q.pop_front();
          start    <= 1'b1;
          in_func  <= nxt.func;
          in_value <= nxt.value;
          // idle burst after this beat
          if (nxt.gap_ok && $urandom_range(0, 3) == 0)
            idle_left = $urandom_range(1, 3);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor: every strobed beat is matched against the oldest prediction
  always @(posedge clk) begin
    fifo_report_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_cnt++;
      end else begin
        want = pending_reports.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          fail_cnt++;
        end
        if (out_popped !== want.popped) begin
          $error("popped: expected %0d, got %0d", want.popped, out_popped);
          fail_cnt++;
        end
        if (out_held !== want.held) begin
          $error("held: expected %0d, got %0d", want.held, out_held);
          fail_cnt++;
        end
        if (out_largest !== want.largest) begin
          $error("largest: expected %0d, got %0d", want.largest, out_largest);
          fail_cnt++;
        end
        if (out_smallest !== want.smallest) begin
          $error("smallest: expected %0d, got %0d", want.smallest, out_smallest);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int   random_cnt;
    int   seg_len;
    int   seg_kind;
    int   push_pct;
    int   i;
    bit   seg_gaps;
    bit   seg_drain;
    bit   first_seg;
    func_t f;

    // directed: pop from empty
    add_cmd(FUNC_POP, '0, 1'b1, 1'b0);
    // extremes and the all-ones pattern, then ties on both extremes
    add_cmd(FUNC_PUSH, VAL_MAX, 1'b1, 1'b0);
    add_cmd(FUNC_PUSH, VAL_MIN, 1'b1, 1'b0);
    add_cmd(FUNC_PUSH, '0, 1'b1, 1'b0);
    add_cmd(FUNC_PUSH, -1, 1'b1, 1'b0);
    add_cmd(FUNC_PUSH, VAL_MAX, 1'b1, 1'b0);
    add_cmd(FUNC_PUSH, VAL_MIN, 1'b1, 1'b0);
    // first max and first min leave while their twins stay
    add_cmd(FUNC_POP, '0, 1'b1, 1'b0);
    add_cmd(FUNC_POP, '0, 1'b1, 1'b0);
    add_cmd(FUNC_POP, '0, 1'b1, 1'b0);
    // alternating bit patterns
    add_cmd(FUNC_PUSH, 32'h5555_5555, 1'b1, 1'b0);
    add_cmd(FUNC_PUSH, 32'hAAAA_AAAA, 1'b1, 1'b0);
    // drain to empty so the extremes fall back, then pop from empty again
    for (i = 0; i < 6; i++)
      add_cmd(FUNC_POP, VAL_MAX, 1'b1, 1'b0);

    // random: fill runs past full, drain runs past empty, and mixed walks
    random_cnt = 0;
    first_seg  = 1'b1;
    while (random_cnt < RANDOM_CMDS) begin
      seg_kind  = $urandom_range(0, 3);
      seg_gaps  = ($urandom_range(0, 2) != 0);
      seg_drain = first_seg || ($urandom_range(0, 7) == 0);
      push_pct  = $urandom_range(30, 70);
      seg_len   = (seg_kind < 2) ? $urandom_range(12, 22) : $urandom_range(10, 40);
      first_seg = 1'b0;
      for (i = 0; i < seg_len; i++) begin
        case (seg_kind)
          0:       f = FUNC_PUSH;
          1:       f = FUNC_POP;
          default: f = ($urandom_range(1, 100) <= push_pct) ? FUNC_PUSH : FUNC_POP;
        endcase
        // pop carries a random value too, which must be ignored
        add_cmd(f, pick_value(), seg_gaps && (random_cnt < RANDOM_CMDS - QUIET_TAIL),
                seg_drain && (i == 0));
        random_cnt++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // wait for the last beat to go and every result to come back
    @(posedge clk);
    while (cmd_q.size() != 0 || start || pending_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_reports.size() != 0) begin
      $error("%0d results never arrived", pending_reports.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
